>>> hdl/double_sha256_nonce_check_assert.svh
// Assertion macros for the double SHA-256 nonce checker.
`ifndef DOUBLE_SHA256_NONCE_CHECK_ASSERT_SVH
`define DOUBLE_SHA256_NONCE_CHECK_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define DSN_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error("assertion failed");
`define DSN_ASSERT_RST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define DSN_ASSERT(lbl, clk, rstn, prop)
`define DSN_ASSERT_RST(lbl, clk, prop)
`endif
`endif

>>> hdl/dsha_pkg.sv
// Shared types, constants and SHA-256 functions for the nonce checker.
`default_nettype none
package dsha_pkg;
  localparam int unsigned NumRounds = 64;
  localparam int unsigned NumRegs = 6;
  localparam int unsigned AddrW = 6;

  typedef enum logic [2:0] {
    RegMid01 = 3'd0,
    RegMid23 = 3'd1,
    RegMid45 = 3'd2,
    RegMid67 = 3'd3,
    RegTail01 = 3'd4,
    RegTail2 = 3'd5
  } reg_idx_e;

  typedef logic [31:0] word_t;
  typedef word_t [7:0] hstate_t;
  typedef word_t [15:0] wwin_t;

  typedef struct packed {
    hstate_t mid;
    word_t tail0;
    word_t tail1;
    word_t tail2;
  } cfg_t;

  localparam word_t [63:0] RoundK = '{
    32'hc67178f2, 32'hbef9a3f7, 32'ha4506ceb, 32'h90befffa,
    32'h8cc70208, 32'h84c87814, 32'h78a5636f, 32'h748f82ee,
    32'h682e6ff3, 32'h5b9cca4f, 32'h4ed8aa4a, 32'h391c0cb3,
    32'h34b0bcb5, 32'h2748774c, 32'h1e376c08, 32'h19a4c116,
    32'h106aa070, 32'hf40e3585, 32'hd6990624, 32'hd192e819,
    32'hc76c51a3, 32'hc24b8b70, 32'ha81a664b, 32'ha2bfe8a1,
    32'h92722c85, 32'h81c2c92e, 32'h766a0abb, 32'h650a7354,
    32'h53380d13, 32'h4d2c6dfc, 32'h2e1b2138, 32'h27b70a85,
    32'h14292967, 32'h06ca6351, 32'hd5a79147, 32'hc6e00bf3,
    32'hbf597fc7, 32'hb00327c8, 32'ha831c66d, 32'h983e5152,
    32'h76f988da, 32'h5cb0a9dc, 32'h4a7484aa, 32'h2de92c6f,
    32'h240ca1cc, 32'h0fc19dc6, 32'hefbe4786, 32'he49b69c1,
    32'hc19bf174, 32'h9bdc06a7, 32'h80deb1fe, 32'h72be5d74,
    32'h550c7dc3, 32'h243185be, 32'h12835b01, 32'hd807aa98,
    32'hab1c5ed5, 32'h923f82a4, 32'h59f111f1, 32'h3956c25b,
    32'he9b5dba5, 32'hb5c0fbcf, 32'h71374491, 32'h428a2f98
  };

  localparam hstate_t InitH = '{
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  function automatic word_t rotr(word_t x, int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic hstate_t sha_round(hstate_t s, word_t kw);
    word_t t1;
    word_t t2;
    hstate_t r;
    t1 = s[7] + (rotr(s[4], 6) ^ rotr(s[4], 11) ^ rotr(s[4], 25))
         + ((s[4] & s[5]) ^ (~s[4] & s[6])) + kw;
    t2 = (rotr(s[0], 2) ^ rotr(s[0], 13) ^ rotr(s[0], 22))
         + ((s[0] & s[1]) ^ (s[0] & s[2]) ^ (s[1] & s[2]));
    r[7] = s[6];
    r[6] = s[5];
    r[5] = s[4];
    r[4] = s[3] + t1;
    r[3] = s[2];
    r[2] = s[1];
    r[1] = s[0];
    r[0] = t1 + t2;
    sha_round = r;
  endfunction

  function automatic wwin_t sched_shift(wwin_t w);
    word_t s0;
    word_t s1;
    wwin_t r;
    s0 = rotr(w[1], 7) ^ rotr(w[1], 18) ^ (w[1] >> 3);
    s1 = rotr(w[14], 17) ^ rotr(w[14], 19) ^ (w[14] >> 10);
    for (int i = 0; i < 15; i++) begin
      r[i] = w[i + 1];
    end
    r[15] = w[0] + s0 + w[9] + s1;
    sched_shift = r;
  endfunction
endpackage
`default_nettype wire

>>> hdl/dsha_regs.sv
// APB configuration registers for midstate and tail words.
`default_nettype none
module dsha_regs
  import dsha_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [AddrW-1:0]  paddr,
  input  wire logic [63:0]       pwdata,
  output logic      [63:0]       prdata,
  output logic                   pready,
  output cfg_t                   cfg_o
);
  logic [63:0] regs_q [NumRegs];
  logic [2:0] idx;
  logic wr;

  assign idx = paddr[AddrW-1:3];
  assign wr = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumRegs; i++) regs_q[i] <= '0;
    end else if (wr) begin
      case (idx)
        RegMid01, RegMid23, RegMid45, RegMid67, RegTail01: regs_q[idx] <= pwdata;
        RegTail2: regs_q[idx] <= {32'd0, pwdata[31:0]};
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    if (idx < 3'(NumRegs) && paddr[2:0] == 3'd0) prdata = regs_q[idx];
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      cfg_o.mid[2*i]   = regs_q[i][63:32];
      cfg_o.mid[2*i+1] = regs_q[i][31:0];
    end
    cfg_o.tail0 = regs_q[RegTail01][63:32];
    cfg_o.tail1 = regs_q[RegTail01][31:0];
    cfg_o.tail2 = regs_q[RegTail2][31:0];
  end
endmodule
`default_nettype wire

>>> hdl/dsha_core.sv
// Fully unrolled SHA-256 compression, one round per pipeline stage.
`default_nettype none
module dsha_core
  import dsha_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    en_i,
  input  wire logic    valid_i,
  input  wire hstate_t h_i,
  input  wire wwin_t   w_i,
  input  wire word_t   tag_i,
  output logic         valid_o,
  output hstate_t      h_o,
  output word_t        tag_o
);
  for (genvar r = 0; r < NumRounds; r++) begin : g_rnd
    hstate_t st_in;
    hstate_t init_in;
    wwin_t   w_in;
    word_t   tag_in;
    logic    v_in;
    hstate_t st_q;
    hstate_t init_q;
    wwin_t   w_q;
    word_t   tag_q;
    logic    v_q;

    if (r == 0) begin : g_head
      assign st_in = h_i;
      assign init_in = h_i;
      assign w_in = w_i;
      assign tag_in = tag_i;
      assign v_in = valid_i;
    end else begin : g_link
      assign st_in = g_rnd[r-1].st_q;
      assign init_in = g_rnd[r-1].init_q;
      assign w_in = g_rnd[r-1].w_q;
      assign tag_in = g_rnd[r-1].tag_q;
      assign v_in = g_rnd[r-1].v_q;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q <= 1'b0;
      end else if (en_i) begin
        v_q <= v_in;
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q <= sha_round(st_in, RoundK[r] + w_in[0]);
        init_q <= init_in;
        w_q <= sched_shift(w_in);
        tag_q <= tag_in;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      h_o[i] = g_rnd[NumRounds-1].init_q[i] + g_rnd[NumRounds-1].st_q[i];
    end
  end
  assign valid_o = g_rnd[NumRounds-1].v_q;
  assign tag_o = g_rnd[NumRounds-1].tag_q;
endmodule
`default_nettype wire

>>> hdl/double_sha256_nonce_check.sv
// Top level: two chained SHA-256 pipelines checking one nonce per beat.
// An input beat passes through the round stages of both hashes and then the output register.
// Throughput: one nonce per cycle while the output beat is not held; each SHA-256 round is one pipeline stage.
// The whole pipeline stalls when the output beat is held, so nothing is lost.
// Reset clears all valid bits and configuration registers to zero.
// Configuration must be written only while the pipeline is empty.
`default_nettype none
module double_sha256_nonce_check
  import dsha_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [AddrW-1:0]  paddr,
  input  wire logic [63:0]       pwdata,
  output logic      [63:0]       prdata,
  output logic                   pready,
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  input  wire logic [31:0]       s_axis_tdata,   // nonce
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  // nonce_out, digest_words_0_1, digest_words_2_3, digest_words_4_5, digest_words_6_7
  output logic [287:0]           m_axis_tdata,
  output logic                   m_axis_tuser    // hit
);
  cfg_t cfg;
  logic en;
  logic v1, v2;
  hstate_t h1, h2;
  word_t t1, t2;
  wwin_t blk1, blk2;
  logic out_v_q;
  logic [287:0] out_d_q;
  logic hit_q;

  dsha_regs u_regs (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata,
    .prdata, .pready, .cfg_o(cfg)
  );

  assign en = !out_v_q || m_axis_tready;
  assign s_axis_tready = en;

  always_comb begin
    blk1 = '0;
    blk1[0] = cfg.tail0;
    blk1[1] = cfg.tail1;
    blk1[2] = cfg.tail2;
    blk1[3] = {s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tdata[23:16], s_axis_tdata[31:24]};
    blk1[4] = 32'h80000000;
    blk1[15] = 32'd640;
    blk2 = '0;
    for (int i = 0; i < 8; i++) blk2[i] = h1[i];
    blk2[8] = 32'h80000000;
    blk2[15] = 32'd256;
  end

  dsha_core u_first (
    .clk_i, .rst_ni, .en_i(en), .valid_i(s_axis_tvalid), .h_i(cfg.mid), .w_i(blk1),
    .tag_i(s_axis_tdata), .valid_o(v1), .h_o(h1), .tag_o(t1)
  );

  dsha_core u_second (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v1), .h_i(InitH), .w_i(blk2),
    .tag_i(t1), .valid_o(v2), .h_o(h2), .tag_o(t2)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= v2;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_d_q <= {h2[6], h2[7], h2[4], h2[5], h2[2], h2[3], h2[0], h2[1], t2};
      hit_q <= (h2[7] == 32'd0);
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata = {out_d_q[287:256], out_d_q[255:224], out_d_q[223:0]};
  assign m_axis_tuser = hit_q;

`include "double_sha256_nonce_check_assert.svh"
  `DSN_ASSERT(a_stall_holds, clk_i, rst_ni, (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
  `DSN_ASSERT(a_ready_when_free, clk_i, rst_ni, !m_axis_tvalid |-> s_axis_tready)
  `DSN_ASSERT(a_hit_matches, clk_i, rst_ni, m_axis_tvalid |-> (m_axis_tuser == (m_axis_tdata[255:224] == 32'd0)))
endmodule
`default_nettype wire

>>> test/double_sha256_nonce_check_test.sv
// Testbench for the double SHA-256 nonce checker: predicted digests are compared beat by beat.
module double_sha256_nonce_check_test
  import dsha_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] nonce;
    logic        hit;
    logic [63:0] d01;
    logic [63:0] d23;
    logic [63:0] d45;
    logic [63:0] d67;
  } digest_beat_t;

  localparam int unsigned PipeDepth = 129;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic pready;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [287:0] m_axis_tdata;
  logic m_axis_tuser;

  logic [63:0] cfg_regs [NumRegs];
  digest_beat_t pending_digests [$];
  int errors = 0;
  bit hold_off = 1'b0;
  bit stall_on = 1'b1;

  double_sha256_nonce_check uut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #50ms;
    $display("== FAIL ==");
    $finish;
  end

  function automatic logic [31:0] ror32(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void sha_block(ref logic [31:0] h [8], input logic [31:0] blk [16]);
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2;
    for (int i = 0; i < 16; i++) w[i] = blk[i];
    for (int i = 16; i < 64; i++)
      w[i] = w[i-16] + (ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-7]
             + (ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10));
    for (int i = 0; i < 8; i++) v[i] = h[i];
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
           + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundK[i] + w[i];
      t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
           + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) h[i] += v[i];
  endfunction

  function automatic digest_beat_t header_digest(logic [31:0] nonce);
    logic [31:0] h [8];
    logic [31:0] blk [16];
    digest_beat_t r;
    for (int i = 0; i < 4; i++) begin
      h[2*i] = cfg_regs[i][63:32];
      h[2*i+1] = cfg_regs[i][31:0];
    end
    for (int i = 0; i < 16; i++) blk[i] = '0;
    blk[0] = cfg_regs[RegTail01][63:32];
    blk[1] = cfg_regs[RegTail01][31:0];
    blk[2] = cfg_regs[RegTail2][31:0];
    blk[3] = {nonce[7:0], nonce[15:8], nonce[23:16], nonce[31:24]};
    blk[4] = 32'h8000_0000;
    blk[15] = 32'd640;
    sha_block(h, blk);
    for (int i = 0; i < 16; i++) blk[i] = '0;
    for (int i = 0; i < 8; i++) blk[i] = h[i];
    blk[8] = 32'h8000_0000;
    blk[15] = 32'd256;
    for (int i = 0; i < 8; i++) h[i] = InitH[i];
    sha_block(h, blk);
    r.nonce = nonce;
    r.hit = (h[7] == '0);
    r.d01 = {h[0], h[1]};
    r.d23 = {h[2], h[3]};
    r.d45 = {h[4], h[5]};
    r.d67 = {h[6], h[7]};
    return r;
  endfunction

  task automatic write_reg(reg_idx_e idx, logic [63:0] value);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= AddrW'(8 * int'(idx)); pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    cfg_regs[idx] = (idx == RegTail2) ? {32'h0, value[31:0]} : value;
  endtask

  task automatic send_nonce(logic [31:0] nonce);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= nonce;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_digests.push_back(header_digest(nonce));
  endtask

  task automatic send_burst(int count, bit gaps);
    int run = 0;
    for (int i = 0; i < count; i++) begin
      if (gaps && run == 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(0, 6)) @(posedge clk_i);
        run = $urandom_range(1, 20);
      end
      send_nonce($urandom());
      run--;
    end
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic drain();
    while (pending_digests.size() != 0) @(posedge clk_i);
    repeat (PipeDepth + 10) @(posedge clk_i);
  endtask

  task automatic set_config(logic [63:0] m0, logic [63:0] m1, logic [63:0] m2, logic [63:0] m3,
                            logic [63:0] t01, logic [63:0] t2);
    write_reg(RegMid01, m0);
    write_reg(RegMid23, m1);
    write_reg(RegMid45, m2);
    write_reg(RegMid67, m3);
    write_reg(RegTail01, t01);
    write_reg(RegTail2, t2);
  endtask

  task automatic test_zero_midstate();
    send_nonce(32'h0);
    send_nonce(32'hFFFF_FFFF);
    send_nonce(32'h1234_5678);
    s_axis_tvalid <= 1'b0;
    drain();
  endtask

  task automatic test_directed_extremes();
    set_config('1, '1, '1, '1, '1, '1);
    for (int b = 0; b < 32; b += 4) send_nonce(32'h1 << b);
    send_nonce(32'h0);
    send_nonce(32'hFFFF_FFFF);
    s_axis_tvalid <= 1'b0;
    drain();
    set_config({32'h6a09e667, 32'hbb67ae85}, {32'h3c6ef372, 32'ha54ff53a},
               {32'h510e527f, 32'h9b05688c}, {32'h1f83d9ab, 32'h5be0cd19},
               64'h4a5e1e4b_495fab29, 64'h1d00ffff);
    send_nonce(32'h7c2bac1d);
    send_nonce(32'h5555_AAAA);
    s_axis_tvalid <= 1'b0;
    drain();
  endtask

  task automatic test_random_configs();
    for (int p = 0; p < 4; p++) begin
      set_config({$urandom(), $urandom()}, {$urandom(), $urandom()}, {$urandom(), $urandom()},
                 {$urandom(), $urandom()}, {$urandom(), $urandom()}, {$urandom(), $urandom()});
      send_burst(200, 1'b1);
      drain();
    end
  endtask

  task automatic test_backpressure();
    fork
      send_burst(160, 1'b0);
      begin
        hold_off = 1'b1;
        repeat (300) @(posedge clk_i);
        hold_off = 1'b0;
      end
    join
    drain();
  endtask

  always @(posedge clk_i) begin
    if (hold_off) m_axis_tready <= 1'b0;
    else if (stall_on) m_axis_tready <= ($urandom_range(0, 3) != 0);
    else m_axis_tready <= 1'b1;
  end

  initial begin
    forever begin
      repeat ($urandom_range(50, 300)) @(posedge clk_i);
      stall_on = !stall_on;
    end
  end

  always @(posedge clk_i) begin
    digest_beat_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata[31:0], m_axis_tuser, m_axis_tdata[95:32], m_axis_tdata[159:96],
             m_axis_tdata[223:160], m_axis_tdata[287:224]};
      if (pending_digests.size() == 0) begin
        $error("unexpected beat nonce=%h", got.nonce);
        errors++;
      end else begin
        want = pending_digests.pop_front();
        if (got.nonce !== want.nonce) begin
          $error("nonce_out exp %h got %h", want.nonce, got.nonce); errors++;
        end
        if (got.hit !== want.hit) begin
          $error("hit exp %b got %b", want.hit, got.hit); errors++;
        end
        if (got.d01 !== want.d01) begin
          $error("digest_words_0_1 exp %h got %h", want.d01, got.d01); errors++;
        end
        if (got.d23 !== want.d23) begin
          $error("digest_words_2_3 exp %h got %h", want.d23, got.d23); errors++;
        end
        if (got.d45 !== want.d45) begin
          $error("digest_words_4_5 exp %h got %h", want.d45, got.d45); errors++;
        end
        if (got.d67 !== want.d67) begin
          $error("digest_words_6_7 exp %h got %h", want.d67, got.d67); errors++;
        end
      end
    end
  end

  initial begin
    for (int i = 0; i < NumRegs; i++) cfg_regs[i] = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_zero_midstate();
    test_directed_extremes();
    test_backpressure();
    test_random_configs();
    set_config('0, '0, '0, '0, '0, '0);
    send_burst(40, 1'b1);
    drain();
    if (errors == 0 && pending_digests.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
